// ----- design/sat_pkg.sv -----
// sat_pkg: shared types and constants of the section address translator
// holds request/result payloads, command and status codes, controller links
// no dependencies
`timescale 1ns / 1ps

package sat_pkg;

  localparam int MaxSections = 16;
  localparam int IdxW        = (MaxSections > 1) ? $clog2(MaxSections) : 1;
  localparam int AddrW       = 32;
  localparam int CntW        = 5;
  localparam int SlotW       = 4;
  localparam int CmdW        = 2;
  localparam int StatW       = 2;
  localparam int CfgAddrW    = 3;
  localparam int CfgDataW    = 32;

  // commands
  localparam logic [CmdW-1:0] CMD_LOAD = 2'd0;
  localparam logic [CmdW-1:0] CMD_V2F  = 2'd1;
  localparam logic [CmdW-1:0] CMD_F2V  = 2'd2;

  // lookup status codes
  localparam logic [StatW-1:0] ST_HIT        = 2'd0;
  localparam logic [StatW-1:0] ST_HEADER     = 2'd1;
  localparam logic [StatW-1:0] ST_UNMAPPABLE = 2'd2;
  localparam logic [StatW-1:0] ST_NONE       = 2'd3;

  // register word index (taken from paddr[2])
  localparam logic REG_SECTION_COUNT = 1'b0;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [SlotW-1:0] entry_index;
    logic [AddrW-1:0] query_address;
    logic [AddrW-1:0] section_virtual_base;
    logic [AddrW-1:0] section_virtual_length;
    logic [AddrW-1:0] section_file_base;
    logic [AddrW-1:0] section_file_length;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] translated_address;
    logic [StatW-1:0] lookup_status;
    logic [SlotW-1:0] hit_section;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic scan_req;
    logic scan_last;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ----- design/sat_ctrl.sv -----
// sat_ctrl: command sequencer of the section address translator
// walks idle, table scan and result cycles; drives datapath commands
// depends on sat_pkg
`timescale 1ns / 1ps

module sat_ctrl import sat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy
);

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = stat.scan_req ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctl.accept    = (state == S_IDLE) && start;
  assign ctl.scan_step = (state == S_SCAN);
  assign ctl.finish    = (state == S_DONE);
  assign busy          = (state != S_IDLE);

endmodule

// ----- design/sat_datapath.sv -----
// sat_datapath: section tables, single-entry scan comparator and result register
// driven by sat_ctrl commands; reports scan start and end status
// depends on sat_pkg
`timescale 1ns / 1ps

module sat_datapath import sat_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  ctl_t            ctl,
  output stat_t           stat,
  input  req_t            request,
  input  logic [CntW-1:0] count,
  output rsp_t            result,
  output logic            done
);

  logic [AddrW-1:0] vbase [MaxSections];
  logic [AddrW-1:0] vlen  [MaxSections];
  logic [AddrW-1:0] fbase [MaxSections];
  logic [AddrW-1:0] flen  [MaxSections];

  logic [CmdW-1:0]  cmd;
  logic [AddrW-1:0] query;
  logic             load_ok;
  logic [IdxW-1:0]  idx;
  logic             ref_found;
  logic [AddrW-1:0] ref_own;
  logic [AddrW-1:0] ref_file;
  logic             best_found;
  logic [AddrW-1:0] best_own;
  logic [AddrW-1:0] best_other;
  logic [IdxW-1:0]  best_idx;

  logic [CntW-1:0]  active;
  logic             slot_ok;
  logic             v2f;
  logic [AddrW-1:0] own_b;
  logic [AddrW-1:0] other_b;
  logic [AddrW-1:0] offs;
  logic [AddrW-1:0] vlim;
  logic             hit;
  logic             ref_take;
  logic             best_take;
  rsp_t             res;

  assign active = (count > CntW'(MaxSections)) ? CntW'(MaxSections) : count;
  assign slot_ok = ({1'b0, request.entry_index} < (SlotW + 1)'(MaxSections));

  assign stat.scan_req = ((request.command == CMD_V2F) || (request.command == CMD_F2V))
                         && (request.query_address != '0) && (active != '0);
  assign stat.scan_last = ((CntW'(idx) + CntW'(1)) == active);

  // one entry per cycle
  assign v2f     = (cmd == CMD_V2F);
  assign own_b   = v2f ? vbase[idx] : fbase[idx];
  assign other_b = v2f ? fbase[idx] : vbase[idx];
  assign offs    = query - own_b;
  assign vlim    = (vlen[idx] == '0) ? '0 : vlen[idx] - AddrW'(1);
  assign hit     = (query >= own_b) && (v2f ? (offs <= vlim) : (offs < flen[idx]));
  assign ref_take  = (own_b != '0) && (!ref_found || (own_b < ref_own));
  assign best_take = hit && (!best_found || (own_b < best_own));

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      ref_found  <= 1'b0;
      best_found <= 1'b0;
      cmd        <= CMD_LOAD;
      load_ok    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.accept) begin
        idx        <= '0;
        ref_found  <= 1'b0;
        best_found <= 1'b0;
        cmd        <= request.command;
        load_ok    <= slot_ok;
      end else if (ctl.scan_step) begin
        idx <= idx + IdxW'(1);
        if (ref_take) begin
          ref_found <= 1'b1;
        end
        if (best_take) begin
          best_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      query <= request.query_address;
      if ((request.command == CMD_LOAD) && slot_ok) begin
        vbase[request.entry_index[IdxW-1:0]] <= request.section_virtual_base;
        vlen[request.entry_index[IdxW-1:0]]  <= request.section_virtual_length;
        fbase[request.entry_index[IdxW-1:0]] <= request.section_file_base;
        flen[request.entry_index[IdxW-1:0]]  <= request.section_file_length;
      end
    end else if (ctl.scan_step) begin
      if (ref_take) begin
        ref_own  <= own_b;
        ref_file <= fbase[idx];
      end
      if (best_take) begin
        best_own   <= own_b;
        best_other <= other_b;
        best_idx   <= idx;
      end
    end
    if (ctl.finish) begin
      result <= res;
    end
  end

  always_comb begin
    res.translated_address = '0;
    res.lookup_status      = ST_NONE;
    res.hit_section        = '0;
    if (cmd == CMD_LOAD) begin
      if (load_ok) begin
        res.lookup_status = ST_HIT;
      end
    end else if (((cmd == CMD_V2F) || (cmd == CMD_F2V)) && ref_found) begin
      if (query < ref_own) begin
        res.translated_address = query;
        res.lookup_status = (v2f && (query >= ref_file)) ? ST_UNMAPPABLE : ST_HEADER;
      end else if (best_found) begin
        res.translated_address = query - best_own + best_other;
        res.lookup_status      = ST_HIT;
        res.hit_section        = SlotW'(best_idx);
      end
    end
  end

endmodule

// ----- design/section_address_translator.sv -----
// section_address_translator: top level; a load writes one table entry, a lookup walks
// entries 0..n-1 with n = min(section_count, 16) and then strobes the result; a load or a
// command with nothing to scan goes straight to the result state; the next start is taken
// in the strobe cycle, so a new transfer is taken only once the last one is through
// synchronous reset clears the sequencer and sets section_count to 1; tables keep contents
// depends on sat_pkg, sat_ctrl, sat_datapath
`timescale 1ns / 1ps

module section_address_translator import sat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                request,
  output logic                done,
  output rsp_t                result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [CntW-1:0] section_count;
  logic            cfg_write;
  ctl_t            ctl;
  stat_t           stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= CntW'(1);
    end else if (cfg_write && (paddr[CfgAddrW-1] == REG_SECTION_COUNT)) begin
      section_count <= pwdata[CntW-1:0];
    end
  end

  assign prdata = (paddr[CfgAddrW-1] == REG_SECTION_COUNT)
                  ? CfgDataW'(section_count) : '0;

  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  sat_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .stat    (stat),
    .request (request),
    .count   (section_count),
    .result  (result),
    .done    (done)
  );

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_hit_index: assert property (@(posedge clk) disable iff (rst)
    (done && (result.lookup_status != ST_HIT)) |-> (result.hit_section == '0))
    else $error("section index reported without a hit");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.lookup_status == ST_NONE)) |-> (result.translated_address == '0))
    else $error("address reported with no section");
`endif

endmodule

// ----- tb/sv/tb_section_address_translator.sv -----
// tb_section_address_translator: self-checking testbench of the section address translator
// directed and random section loads and lookups, checked against an in-bench translation model
// depends on sat_pkg and section_address_translator
`timescale 1ns / 1ps

module tb_section_address_translator;
  import sat_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int CycleLimit  = 500_000;
  localparam int PhaseItems  = 112;
  localparam int RandPhases  = 12;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  req_t                request = '0;
  logic                done;
  rsp_t                result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  section_address_translator dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // translation model state
  logic [AddrW-1:0] sect_vbase [MaxSections] = '{default: '0};
  logic [AddrW-1:0] sect_vlen  [MaxSections] = '{default: '0};
  logic [AddrW-1:0] sect_fbase [MaxSections] = '{default: '0};
  logic [AddrW-1:0] sect_flen  [MaxSections] = '{default: '0};
  logic [CntW-1:0]  section_count = 5'd1;

  // stimulus-side copy of the table, used to aim queries
  logic [AddrW-1:0]       plan_vbase [MaxSections] = '{default: '0};
  logic [AddrW-1:0]       plan_vlen  [MaxSections] = '{default: '0};
  logic [AddrW-1:0]       plan_fbase [MaxSections] = '{default: '0};
  logic [AddrW-1:0]       plan_flen  [MaxSections] = '{default: '0};
  logic [MaxSections-1:0] plan_loaded = '0;

  req_t pending_q [$];
  rsp_t translation_q [$];
  rsp_t want_rsp;
  logic item_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  int   n_checked = 0, n_loads = 0, n_hits = 0, n_header = 0, n_unmap = 0, n_none = 0;
  int   n_settings = 0;
  logic [CntW-1:0] first_counts [6] = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd2};
  logic [CntW-1:0] phase_count;

  function automatic rsp_t translate_section_request(req_t r);
    rsp_t             res;
    int               n, refi, best;
    logic             v2f, hit;
    logic [AddrW-1:0] q, own_i, own_ref, own_best, other_best;
    res = '0;
    res.lookup_status = ST_NONE;
    n = (section_count > MaxSections) ? MaxSections : section_count;
    q = r.query_address;
    if (r.command == CMD_LOAD) begin
      sect_vbase[r.entry_index] = r.section_virtual_base;
      sect_vlen[r.entry_index]  = r.section_virtual_length;
      sect_fbase[r.entry_index] = r.section_file_base;
      sect_flen[r.entry_index]  = r.section_file_length;
      res.lookup_status = ST_HIT;
    end else if ((r.command == CMD_V2F || r.command == CMD_F2V) && q != 0) begin
      v2f = (r.command == CMD_V2F);
      refi = -1;
      own_ref = '0;
      for (int i = 0; i < n; i++) begin
        own_i = v2f ? sect_vbase[i] : sect_fbase[i];
        if (own_i != 0 && (refi < 0 || own_i < own_ref)) begin
          refi = i;
          own_ref = own_i;
        end
      end
      if (refi >= 0) begin
        if (q < own_ref) begin
          res.translated_address = q;
          res.lookup_status = (v2f && q >= sect_fbase[refi]) ? ST_UNMAPPABLE : ST_HEADER;
        end else begin
          best = -1;
          own_best = '0;
          other_best = '0;
          for (int i = 0; i < n; i++) begin
            if (v2f) begin
              hit = q >= sect_vbase[i] &&
                    (q - sect_vbase[i]) <= ((sect_vlen[i] != 0) ? sect_vlen[i] - 32'd1 : 32'd0);
            end else begin
              hit = q >= sect_fbase[i] && (q - sect_fbase[i]) < sect_flen[i];
            end
            own_i = v2f ? sect_vbase[i] : sect_fbase[i];
            if (hit && (best < 0 || own_i < own_best)) begin
              best = i;
              own_best = own_i;
              other_best = v2f ? sect_fbase[i] : sect_vbase[i];
            end
          end
          if (best >= 0) begin
            res.translated_address = q - own_best + other_best;
            res.lookup_status = ST_HIT;
            res.hit_section = SlotW'(best);
          end
        end
      end
    end
    return res;
  endfunction

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        request <= pending_q.pop_front();
        start <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                     $urandom_range(1, ($urandom_range(0, 1) != 0) ? 4 : 25);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // result check and transfer tracking
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (translation_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, result);
          fail_cnt++;
        end else begin
          want_rsp = translation_q.pop_front();
          n_checked++;
          check_field("translated_address", want_rsp.translated_address,
                      result.translated_address);
          check_field("lookup_status", 32'(want_rsp.lookup_status), 32'(result.lookup_status));
          check_field("hit_section", 32'(want_rsp.hit_section), 32'(result.hit_section));
          case (want_rsp.lookup_status)
            ST_HIT:        n_hits++;
            ST_HEADER:     n_header++;
            ST_UNMAPPABLE: n_unmap++;
            default:       n_none++;
          endcase
        end
      end
      if (start && !busy) begin
        translation_q.push_back(translate_section_request(request));
        if (request.command == CMD_LOAD) n_loads++;
        item_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, translation_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_req(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] slot,
                          input logic [AddrW-1:0] q, input logic [AddrW-1:0] vb,
                          input logic [AddrW-1:0] vl, input logic [AddrW-1:0] fb,
                          input logic [AddrW-1:0] fl);
    req_t r;
    r.command = cmd;
    r.entry_index = slot;
    r.query_address = q;
    r.section_virtual_base = vb;
    r.section_virtual_length = vl;
    r.section_file_base = fb;
    r.section_file_length = fl;
    pending_q.push_back(r);
    if (cmd == CMD_LOAD) begin
      plan_vbase[slot] = vb;
      plan_vlen[slot] = vl;
      plan_fbase[slot] = fb;
      plan_flen[slot] = fl;
      plan_loaded[slot] = 1'b1;
    end
  endtask

  function automatic logic [AddrW-1:0] corner_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_section_load(input int slot);
    int               kind, j;
    logic [AddrW-1:0] vb, vl, fb, fl;
    kind = $urandom_range(0, 9);
    // image-like layout by default
    vb = $urandom_range(1, 64) << 12;
    vl = $urandom_range(0, 32'h4000);
    fb = $urandom_range(1, 128) << 9;
    fl = $urandom_range(0, 32'h4000);
    if (kind == 5 || kind == 6) begin
      vb = $urandom;
      vl = $urandom;
      fb = $urandom;
      fl = $urandom;
    end else if (kind == 7) begin
      vb = corner_word();
      vl = corner_word();
      fb = corner_word();
      fl = corner_word();
    end else if (kind >= 8) begin
      // share bases with another entry for ties and overlaps
      j = $urandom_range(0, MaxSections - 1);
      if (plan_loaded[j]) begin
        vb = plan_vbase[j];
        fb = plan_fbase[j];
      end
    end
    push_req(CMD_LOAD, SlotW'(slot), $urandom, vb, vl, fb, fl);
  endtask

  task automatic queue_section_lookup(input logic [CmdW-1:0] cmd, input int n);
    int               j;
    logic [AddrW-1:0] base, len, q;
    q = $urandom;
    if (n > 0) begin
      j = $urandom_range(0, n - 1);
      base = (cmd == CMD_V2F) ? plan_vbase[j] : plan_fbase[j];
      len = (cmd == CMD_V2F) ? plan_vlen[j] : plan_flen[j];
      case ($urandom_range(0, 9))
        0, 1, 2, 3: q = base + ((len == 0) ? 32'd0 : $urandom_range(0, len - 32'd1));
        4: begin
          case ($urandom_range(0, 3))
            0:       q = base;
            1:       q = base + len - 32'd1;
            2:       q = base + len;
            default: q = base - 32'd1;
          endcase
        end
        5:       q = $urandom_range(0, base);
        6:       q = '0;
        7:       q = corner_word();
        8:       q = $urandom;
        default: q = $urandom_range(1, 32'h1_0000);
      endcase
    end
    push_req(cmd, SlotW'($urandom), q, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic queue_random_phase(input logic [CntW-1:0] count, input int items);
    int n, roll;
    n = (count > MaxSections) ? MaxSections : count;
    for (int s = 0; s < n; s++) begin
      if (!plan_loaded[s]) queue_section_load(s);
    end
    repeat ($urandom_range(0, 4)) queue_section_load($urandom_range(0, MaxSections - 1));
    repeat (items) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_section_load($urandom_range(0, MaxSections - 1));
      end else if (roll < 12) begin
        push_req(CMD_UNUSED, SlotW'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        queue_section_lookup((roll < 56) ? CMD_V2F : CMD_F2V, n);
      end
    end
  endtask

  task automatic wait_drained();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(negedge clk);
      if (pending_q.size() == 0 && !start && translation_q.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_section_count(input logic [CntW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SECTION_COUNT, 2'b00};
    pwdata <= CfgDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    section_count = value;
    n_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CntW-1:0] !== value) begin
      $display("%0t: section_count readback mismatch, expected %h, actual %h",
               $time, value, prdata[CntW-1:0]);
      fail_cnt++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one section, reset count: header, unmappable, hit, range ends, zero query, unused command
    push_req(CMD_LOAD, 4'd0, 32'h0, 32'h1000, 32'h2000, 32'h400, 32'h1800);
    push_req(CMD_V2F, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h200, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h800, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h1000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h2fff, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h3000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'h3ff, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'h400, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'h1bff, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_UNUSED, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff);

    // no active sections
    wait_drained();
    write_section_count(5'd0);
    push_req(CMD_V2F, 4'd0, 32'h1000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'h400, 32'h0, 32'h0, 32'h0, 32'h0);

    // overlaps, base ties, one-byte section, file range past the top of the space
    wait_drained();
    write_section_count(5'd3);
    push_req(CMD_LOAD, 4'd1, 32'h0, 32'h8000, 32'h0, 32'hffff_ff00, 32'h1000);
    push_req(CMD_LOAD, 4'd2, 32'h0, 32'h800, 32'h900, 32'h400, 32'h10);
    push_req(CMD_V2F, 4'd0, 32'h100, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h500, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h1000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h8000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_V2F, 4'd0, 32'h8001, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'h408, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0);
    push_req(CMD_F2V, 4'd0, 32'h3ff, 32'h0, 32'h0, 32'h0, 32'h0);

    for (int p = 0; p < RandPhases; p++) begin
      phase_count = (p < 6) ? first_counts[p] : CntW'($urandom_range(0, 31));
      wait_drained();
      write_section_count(phase_count);
      queue_random_phase(phase_count, PhaseItems);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("%0d transfers checked: %0d loads, %0d section hits, %0d header, %0d unmappable,",
             n_checked, n_loads, n_hits - n_loads, n_header, n_unmap);
    $display("%0d without section, over %0d section_count settings, %0d mismatches",
             n_none, n_settings, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/sat_pkg.sv
design/sat_ctrl.sv
design/sat_datapath.sv
design/section_address_translator.sv
tb/sv/tb_section_address_translator.sv
